>>> src/mwsf_pkg.sv
`timescale 1ns / 1ps
// Package for the mecanum wheel speed framer: shared types, function codes,
// frame constants and helper functions. No dependencies.
package mwsf_pkg;

    typedef logic signed [15:0] speed_t;

    typedef struct packed {
        speed_t fl;
        speed_t rl;
        speed_t rr;
        speed_t fr;
    } wheel_set_t;

    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int unsigned SPAN_W      = 18;
    localparam int unsigned VEL_W       = 16;
    localparam int unsigned MAG_W       = VEL_W + 1;
    localparam int unsigned PROD_W      = MAG_W + SPAN_W;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned SUM_W       = 21;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned FRAME_LEN   = 12;
    localparam int unsigned IDX_W       = 4;

    localparam logic [SPAN_W-1:0] HALF_SPAN_RESET = 18'd23167;
    localparam logic [IDX_W-1:0]  FRAME_LAST      = IDX_W'(FRAME_LEN - 1);

    localparam logic [7:0] SOF0 = 8'h24;
    localparam logic [7:0] SOF1 = 8'h23;
    localparam logic [7:0] EOF0 = 8'h25;
    localparam logic [7:0] EOF1 = 8'h21;

    localparam logic signed [SUM_W-1:0] SPEED_MAX = 21'sd32767;
    localparam logic signed [SUM_W-1:0] SPEED_MIN = -21'sd32768;

    function automatic speed_t sat16(input logic signed [SUM_W-1:0] v);
        speed_t r;
        if (v > SPEED_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < SPEED_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_byte_sel(input wheel_set_t ws,
                                                  input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = SOF0;
            4'd1:    b = SOF1;
            4'd2:    b = ws.fl[7:0];
            4'd3:    b = ws.fl[15:8];
            4'd4:    b = ws.rl[7:0];
            4'd5:    b = ws.rl[15:8];
            4'd6:    b = ws.rr[7:0];
            4'd7:    b = ws.rr[15:8];
            4'd8:    b = ws.fr[7:0];
            4'd9:    b = ws.fr[15:8];
            4'd10:   b = EOF0;
            4'd11:   b = EOF1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/mwsf_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands and ticks, computes and stores wheel speeds,
// and pushes a snapshot of changed speeds into the frame queue. Uses mwsf_pkg.
module mwsf_front
    import mwsf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [SPAN_W-1:0]      cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_func,
    input  logic signed [VEL_W-1:0] in_vx,
    input  logic signed [VEL_W-1:0] in_vy,
    input  logic signed [VEL_W-1:0] in_yaw,
    input  logic                   q_full,
    output logic                   q_push,
    output wheel_set_t             q_data
);

    logic [SPAN_W-1:0]        half_span_reg;
    logic                     s1_valid_reg;
    logic                     s1_func_reg;
    logic signed [VEL_W-1:0]  s1_vx_reg;
    logic signed [VEL_W-1:0]  s1_vy_reg;
    logic                     s1_neg_reg;
    logic [PROD_W-1:0]        s1_prod_reg;
    wheel_set_t               wheel_reg;
    wheel_set_t               sent_reg;

    logic                     in_fire;
    logic [MAG_W-1:0]         yaw_mag;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-FRAC_W-1:0] kw_mag;
    logic signed [SUM_W-1:0]  kw;
    logic signed [SUM_W-1:0]  vx_ext;
    logic signed [SUM_W-1:0]  vy_ext;
    wheel_set_t               wheel_next;
    logic                     changed;
    logic                     s1_done;
    logic                     cmd_done;

    assign in_fire   = in_valid && in_ready;
    assign yaw_mag   = in_yaw[VEL_W-1] ? (MAG_W'(0) - {in_yaw[VEL_W-1], in_yaw})
                                       : {1'b0, in_yaw};
    assign prod_next = PROD_W'(yaw_mag) * PROD_W'(half_span_reg);

    assign kw_mag = s1_prod_reg[PROD_W-1:FRAC_W];
    assign kw     = s1_neg_reg ? (SUM_W'(0) - SUM_W'(kw_mag)) : SUM_W'(kw_mag);
    assign vx_ext = SUM_W'(s1_vx_reg);
    assign vy_ext = SUM_W'(s1_vy_reg);

    always_comb
    begin
        wheel_next.fl = sat16(vx_ext - vy_ext - kw);
        wheel_next.rl = sat16(vx_ext + vy_ext - kw);
        wheel_next.rr = sat16(vx_ext - vy_ext + kw);
        wheel_next.fr = sat16(vx_ext + vy_ext + kw);
    end

    assign changed  = (wheel_reg != sent_reg);
    assign q_push   = s1_valid_reg && (s1_func_reg == FUNC_TICK) && changed && !q_full;
    assign cmd_done = s1_valid_reg && (s1_func_reg == FUNC_CMD);
    assign s1_done  = cmd_done || (s1_valid_reg && (!changed || !q_full));
    assign in_ready = !s1_valid_reg || s1_done;
    assign q_data   = wheel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_span_reg <= HALF_SPAN_RESET;
            s1_valid_reg  <= 1'b0;
            wheel_reg     <= '0;
            sent_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_span_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (cmd_done)
            begin
                wheel_reg <= wheel_next;
            end
            if (q_push)
            begin
                sent_reg <= wheel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= in_func;
            s1_vx_reg   <= in_vx;
            s1_vy_reg   <= in_vy;
            s1_neg_reg  <= in_yaw[VEL_W-1];
            s1_prod_reg <= prod_next;
        end
    end

endmodule

>>> src/mwsf_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of wheel speed snapshots between the front end and the
// frame serializer. Uses mwsf_pkg.
module mwsf_queue
    import mwsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wheel_set_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output wheel_set_t head_data
);

    wheel_set_t  entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("Snapshot pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("Snapshot popped from an empty queue.");
`endif

endmodule

>>> src/mwsf_back.sv
`timescale 1ns / 1ps
// Frame serializer: turns the queue head into twelve output beats held in an
// output register. Uses mwsf_pkg.
module mwsf_back
    import mwsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  wheel_set_t head_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             load;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && (idx_reg == FRAME_LAST);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = (idx_reg == FRAME_LAST) ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= frame_byte_sel(head_data, idx_reg);
            last_reg <= (idx_reg == FRAME_LAST);
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= FRAME_LAST)
        else $error("Beat index ran past the end of the frame.");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && out_last) |-> (idx_reg == '0 || load))
        else $error("Frame end delivered while the serializer is mid-frame.");
`endif

endmodule

>>> src/mecanum_wheel_speed_framer.sv
`timescale 1ns / 1ps
// Top level of the mecanum wheel speed framer: front end, snapshot queue and
// frame serializer. Uses mwsf_pkg, mwsf_front, mwsf_queue and mwsf_back.
//
// Input beats carry a velocity command (tuser 0) or a send tick (tuser 1).
// The front end takes one beat per cycle unless the queue is full: a
// two-stage path registers the yaw product, then updates the four stored
// wheel speeds or, on a tick with changed speeds, pushes a snapshot into a
// two-deep queue. Each snapshot leaves as a twelve-beat frame, one beat per
// cycle while the receiver is ready, through an output register, so
// frame-producing ticks are limited by the one-byte output port; commands
// and ticks that send nothing never wait on it unless the queue is full.
module mecanum_wheel_speed_framer
    import mwsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [17:0] cfg_wdata,       // half_span_q16
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // vx_mm, vy_mm, yaw_mrad
    input  logic        s_axis_tuser,    // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // frame_byte
    output logic        m_axis_tlast
);

    logic       q_full;
    logic       q_push;
    wheel_set_t q_push_data;
    logic       q_pop;
    logic       q_head_valid;
    wheel_set_t q_head_data;

    mwsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_vx     (s_axis_tdata[15:0]),
        .in_vy     (s_axis_tdata[31:16]),
        .in_yaw    (s_axis_tdata[47:32]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    mwsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    mwsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

>>> tb/mecanum_wheel_speed_framer_test.sv
`timescale 1ns / 1ps
// Testbench for mecanum_wheel_speed_framer: streams velocity commands and send ticks,
// predicts every frame beat from its own wheel speed model and checks the output stream.
// Depends on mwsf_pkg and the RTL of the framer.
module mecanum_wheel_speed_framer_test;
    import mwsf_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 24;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 86;
    localparam int PRINT_CAP        = 40;

    typedef struct {
        logic   func;
        speed_t vx;
        speed_t vy;
        speed_t yaw;
    } vel_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [17:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    vel_beat_t   pending_beats[$];
    frame_beat_t frame_bytes_due[$];
    vel_beat_t   beat_on_bus;
    frame_beat_t due_beat;

    speed_t      wheel_now[4]  = '{default: '0};
    speed_t      wheel_sent[4] = '{default: '0};
    logic [17:0] span_q16      = HALF_SPAN_RESET;

    speed_t last_vx  = '0;
    speed_t last_vy  = '0;
    speed_t last_yaw = '0;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int mismatches       = 0;
    int cycles           = 0;
    int commands_taken   = 0;
    int ticks_taken      = 0;
    int frames_predicted = 0;
    int beats_checked    = 0;
    int spans_used       = 0;

    mecanum_wheel_speed_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic speed_t clamp_speed(input longint v);
        speed_t r;
        if (v > 32767)
        begin
            r = speed_t'(16'h7fff);
        end
        else if (v < -32768)
        begin
            r = speed_t'(16'h8000);
        end
        else
        begin
            r = speed_t'(v);
        end
        return r;
    endfunction

    // The yaw term is truncated toward zero: the magnitude is scaled, then the sign restored.
    function automatic longint yaw_kw(input speed_t yaw, input logic [17:0] span);
        longint mag;
        longint q;
        mag = (yaw < 0) ? -longint'(yaw) : longint'(yaw);
        q = (mag * longint'(span)) >> 16;
        return (yaw < 0) ? -q : q;
    endfunction

    function automatic void push_due(input logic [7:0] data, input logic last);
        frame_beat_t fb;
        fb.data = data;
        fb.last = last;
        frame_bytes_due.insert(frame_bytes_due.size(), fb);
    endfunction

    function automatic void predict_wheels_and_frame(input vel_beat_t b);
        longint vx;
        longint vy;
        longint kw;
        logic   changed;
        if (b.func == FUNC_CMD)
        begin
            vx = longint'(b.vx);
            vy = longint'(b.vy);
            kw = yaw_kw(b.yaw, span_q16);
            wheel_now[0] = clamp_speed(vx - vy - kw);
            wheel_now[1] = clamp_speed(vx + vy - kw);
            wheel_now[2] = clamp_speed(vx - vy + kw);
            wheel_now[3] = clamp_speed(vx + vy + kw);
            commands_taken++;
        end
        else
        begin
            ticks_taken++;
            changed = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                if (wheel_now[i] != wheel_sent[i])
                begin
                    changed = 1'b1;
                end
            end
            if (changed)
            begin
                push_due(SOF0, 1'b0);
                push_due(SOF1, 1'b0);
                for (int i = 0; i < 4; i++)
                begin
                    push_due(wheel_now[i][7:0], 1'b0);
                    push_due(wheel_now[i][15:8], 1'b0);
                    wheel_sent[i] = wheel_now[i];
                end
                push_due(EOF0, 1'b0);
                push_due(EOF1, 1'b1);
                frames_predicted++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("MISMATCH at cycle %0d: %s", cycles, what);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_wheels_and_frame(beat_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_on_bus = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {beat_on_bus.yaw, beat_on_bus.vy, beat_on_bus.vx};
                    s_axis_tuser  <= beat_on_bus.func;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %02h last %0b",
                                              m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    due_beat = frame_bytes_due.pop_front();
                    if (m_axis_tdata !== due_beat.data)
                    begin
                        report_mismatch($sformatf("frame byte %02h, expected %02h",
                                                  m_axis_tdata, due_beat.data));
                    end
                    if (m_axis_tlast !== due_beat.last)
                    begin
                        report_mismatch($sformatf("tlast %0b, expected %0b",
                                                  m_axis_tlast, due_beat.last));
                    end
                    beats_checked++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still due", cycles,
                     frame_bytes_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic speed_t pick_speed();
        speed_t v;
        case ($urandom_range(3))
            0: v = speed_t'($urandom);
            1: v = speed_t'(int'($urandom_range(600)) - 300);
            2:
            begin
                case ($urandom_range(4))
                    0:       v = speed_t'(16'h7fff);
                    1:       v = speed_t'(16'h8000);
                    2:       v = speed_t'(16'h0000);
                    3:       v = speed_t'(16'hffff);
                    default: v = speed_t'(16'h0001);
                endcase
            end
            default: v = speed_t'(int'($urandom_range(10000)) - 5000);
        endcase
        return v;
    endfunction

    task automatic push_command(input speed_t vx, input speed_t vy, input speed_t yaw);
        vel_beat_t b;
        b.func = FUNC_CMD;
        b.vx   = vx;
        b.vy   = vy;
        b.yaw  = yaw;
        pending_beats.insert(pending_beats.size(), b);
        last_vx  = vx;
        last_vy  = vy;
        last_yaw = yaw;
    endtask

    // Operands of a tick carry random junk that the block has to ignore.
    task automatic push_tick();
        vel_beat_t b;
        b.func = FUNC_TICK;
        b.vx   = speed_t'($urandom);
        b.vy   = speed_t'($urandom);
        b.yaw  = speed_t'($urandom);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic queue_random_traffic(input int count);
        int added;
        int pick;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                push_command(pick_speed(), pick_speed(), pick_speed());
                push_tick();
                added += 2;
            end
            else if (pick < 70)
            begin
                push_tick();
                added += 1;
            end
            else if (pick < 85)
            begin
                push_command(pick_speed(), pick_speed(), pick_speed());
                added += 1;
            end
            else
            begin
                push_command(last_vx, last_vy, last_yaw);
                push_tick();
                added += 2;
            end
        end
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || frame_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_half_span(input logic [17:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        span_q16 = value;
        spans_used++;
    endtask

    task automatic run_phase(input logic [17:0] span, input int idle_pct,
                             input int stall_pct, input int count);
        wait_until_drained();
        write_half_span(span);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_traffic(count);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset half span, no idling on either side.
        push_tick();
        push_command(16'sd0, 16'sd0, 16'sd0);
        push_tick();
        push_command(16'sd100, -16'sd50, 16'sd1000);
        push_tick();
        push_tick();
        push_command(16'sh7fff, 16'sh8000, 16'sh7fff);
        push_tick();
        push_command(16'sh8000, 16'sh7fff, 16'sh8000);
        push_tick();
        push_command(16'sd0, 16'sd0, -16'sd1);
        push_tick();
        push_command(16'sd0, 16'sd0, -16'sd3);
        push_tick();
        push_command(16'sd0, 16'sd0, -16'sd3);
        push_tick();
        push_command(16'sd1, 16'sd1, 16'sd0);
        push_command(16'sd2, -16'sd2, 16'sd5);
        push_tick();
        push_command(-16'sd1, -16'sd1, -16'sd1);
        push_tick();
        push_tick();

        run_phase(18'd0, 0, 0, RANDOM_PER_PHASE);
        run_phase(18'h3ffff, 78, 0, RANDOM_PER_PHASE);
        run_phase(18'($urandom), 0, 78, RANDOM_PER_PHASE);
        run_phase(18'd65536, 15, 15, RANDOM_PER_PHASE);

        // The sender stops halfway and waits for every outstanding frame to leave.
        run_phase(HALF_SPAN_RESET, 0, 0, RANDOM_PER_PHASE / 2);
        wait_until_drained();
        @(negedge clk);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        queue_random_traffic(RANDOM_PER_PHASE / 2);

        wait_until_drained();
        $display("Covered %0d velocity commands and %0d send ticks over %0d half-span settings.",
                 commands_taken, ticks_taken, spans_used + 1);
        $display("Checked %0d frames in %0d beats, %0d mismatches.",
                 frames_predicted, beats_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mwsf_pkg.sv
src/mwsf_front.sv
src/mwsf_queue.sv
src/mwsf_back.sv
src/mecanum_wheel_speed_framer.sv
tb/mecanum_wheel_speed_framer_test.sv
